[rtl/mlr_pkg.sv]
// mlr_pkg: shared constants, types and helpers for the microphone lowpass,
// decimator and sample ring. No dependencies.
package mlr_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = RING_AW + 1;
    localparam int MAX_READ   = 64;
    localparam int CNT_W      = 7;
    localparam int REM_W      = 11;
    localparam int SMP_W      = 16;
    localparam int RAW_W      = 13;
    localparam int Q_SHIFT    = 13;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 16;

    localparam logic [13:0] ALPHA_RST = 14'd4096;
    localparam logic [11:0] MAX_RST   = 12'd4095;
    localparam logic [11:0] MID_RST   = 12'd2048;
    localparam logic [3:0]  GAIN_RST  = 4'd0;
    localparam logic [15:0] STEP_RST  = 16'd20971;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ALPHA = 3'd0,
        CFG_MAX   = 3'd1,
        CFG_MID   = 3'd2,
        CFG_GAIN  = 3'd3,
        CFG_STEP  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SMP,
        S_RD_REQ,
        S_RD_WAIT
    } t_state;

    typedef struct packed {
        logic [13:0] alpha;
        logic [11:0] adc_max;
        logic [11:0] adc_mid;
        logic [3:0]  gain;
        logic [15:0] step;
    } t_cfg;

    // sample path result: done every item, wr only on a phase wrap
    typedef struct packed {
        logic                    done;
        logic                    wr;
        logic signed [SMP_W-1:0] value;
    } t_push;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/mlr_ram.sv]
// mlr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mlr_filter.sv]
// mlr_filter: clamp, Q13 first-order lowpass, phase accumulator and gain stage.
// Depends on mlr_pkg.
module mlr_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [mlr_pkg::RAW_W-1:0] i_raw,
    input  mlr_pkg::t_cfg                 i_cfg,
    output mlr_pkg::t_push                o_push
);

    logic [2:0]                         r_stg;
    logic signed [mlr_pkg::RAW_W-1:0]   r_x;
    logic signed [27:0]                 r_pa;
    logic signed [30:0]                 r_pb;
    logic signed [mlr_pkg::SMP_W-1:0]   r_fv;
    logic [15:0]                        r_phase;
    logic                               r_wrap;
    logic                               r_done;
    logic                               r_wr;
    logic signed [mlr_pkg::SMP_W-1:0]   r_amp;

    logic [11:0]                        w_clamp;
    logic signed [mlr_pkg::RAW_W-1:0]   n_x;
    logic signed [14:0]                 w_alpha;
    logic signed [14:0]                 w_old;
    logic signed [31:0]                 n_acc;
    logic signed [mlr_pkg::SMP_W-1:0]   n_fv;
    logic [16:0]                        n_phase;
    logic signed [31:0]                 w_shl;
    logic signed [mlr_pkg::SMP_W-1:0]   n_amp;

    always_comb begin
        if (i_raw[mlr_pkg::RAW_W-1]) begin
            w_clamp = 12'd0;
        end else if (i_raw[11:0] > i_cfg.adc_max) begin
            w_clamp = i_cfg.adc_max;
        end else begin
            w_clamp = i_raw[11:0];
        end
        n_x     = $signed({1'b0, w_clamp}) - $signed({1'b0, i_cfg.adc_mid});
        w_alpha = $signed({1'b0, i_cfg.alpha});
        // weight of the old value goes negative for alpha above one
        w_old   = 15'sd8192 - w_alpha;
        n_acc   = 32'(r_pa) + 32'(r_pb);
        // arithmetic shift gives the floor for negative sums
        n_fv    = mlr_pkg::sat16(n_acc >>> mlr_pkg::Q_SHIFT);
        n_phase = {1'b0, r_phase} + {1'b0, i_cfg.step};
        w_shl   = 32'(r_fv) <<< i_cfg.gain;
        n_amp   = mlr_pkg::sat16(w_shl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg   <= '0;
            r_fv    <= '0;
            r_phase <= '0;
            r_wrap  <= 1'b0;
            r_done  <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            r_stg  <= {r_stg[1:0], i_start};
            r_done <= r_stg[2];
            r_wr   <= r_stg[2] & r_wrap;
            if (r_stg[1]) begin
                r_fv    <= n_fv;
                r_phase <= n_phase[15:0];
                r_wrap  <= n_phase[16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= n_x;
        end
        if (r_stg[0]) begin
            r_pa <= 28'(r_x) * 28'(w_alpha);
            r_pb <= 31'(r_fv) * 31'(w_old);
        end
        if (r_stg[2]) begin
            r_amp <= n_amp;
        end
    end

    assign o_push = '{done: r_done, wr: r_wr, value: r_amp};

endmodule

[rtl/mic_lowpass_decimate_ring_unit.sv]
// mic_lowpass_decimate_ring_unit: top level with configuration registers, ring
// sequencer and output register. Depends on mlr_pkg, mlr_ram and mlr_filter.
//
//  channel    dir  handshake                     payload
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready tuser operation, tdata raw/count
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready tdata sample/remaining, tlast
//  cfg        in   i_cfg_we                      i_cfg_addr, i_cfg_data
//
// a sample item occupies the block from accept through the four filter stages
// a read item visits S_RD_REQ then S_RD_WAIT for each result, since the ring read
// port is registered; a read giving no result goes straight back to idle
// reset is synchronous and active low; the ring contents are not cleared
// a full output register holds the sequencer until the result is taken
module mic_lowpass_decimate_ring_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // raw_sample[12:0], read_count[19:13]
    input  logic                        i_s_axis_tuser,  // operation[0]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,  // sample[15:0], remaining[26:16]
    output logic                        o_m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic [mlr_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [mlr_pkg::CFG_DW-1:0]  i_cfg_data
);

    mlr_pkg::t_cfg                      r_cfg;
    mlr_pkg::t_state                    r_state;
    mlr_pkg::t_state                    n_state;
    mlr_pkg::t_push                     w_push;

    logic [mlr_pkg::RING_AW-1:0]        r_wr_idx;
    logic [mlr_pkg::RING_AW-1:0]        r_rd_idx;
    logic [mlr_pkg::FILL_W-1:0]         r_fill;
    logic [mlr_pkg::CNT_W-1:0]          r_left;

    logic                               r_out_valid;
    logic [mlr_pkg::SMP_W-1:0]          r_out_sample;
    logic [mlr_pkg::REM_W-1:0]          r_out_rem;
    logic                               r_out_last;

    logic                               w_take;
    logic                               w_is_read;
    logic [mlr_pkg::CNT_W-1:0]          w_count;
    logic [mlr_pkg::CNT_W-1:0]          w_want;
    logic [mlr_pkg::CNT_W-1:0]          n_left;
    logic                               w_out_free;
    logic                               w_ready;
    logic                               w_start;
    logic                               w_ram_we;
    logic                               w_ram_re;
    logic                               w_out_load;
    logic [mlr_pkg::SMP_W-1:0]          w_rdata;
    logic                               w_full;

    assign w_is_read  = (mlr_pkg::t_op'(i_s_axis_tuser) == mlr_pkg::OP_READ);
    assign w_take     = i_s_axis_tvalid & w_ready;
    assign w_out_free = ~r_out_valid | i_m_axis_tready;
    assign w_count    = i_s_axis_tdata[19:13];
    assign w_full     = (r_fill == mlr_pkg::FILL_W'(mlr_pkg::RING_DEPTH));

    // number of results for this read: capped by the limit and by the fill
    always_comb begin
        if (w_count > mlr_pkg::CNT_W'(mlr_pkg::MAX_READ)) begin
            w_want = mlr_pkg::CNT_W'(mlr_pkg::MAX_READ);
        end else begin
            w_want = w_count;
        end
        if (mlr_pkg::FILL_W'(w_want) < r_fill) begin
            n_left = w_want;
        end else begin
            n_left = r_fill[mlr_pkg::CNT_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlr_pkg::S_IDLE: begin
                if (w_take) begin
                    if (!w_is_read) begin
                        n_state = mlr_pkg::S_SMP;
                    end else if (n_left != '0) begin
                        n_state = mlr_pkg::S_RD_REQ;
                    end
                end
            end
            mlr_pkg::S_SMP: begin
                if (w_push.done) begin
                    n_state = mlr_pkg::S_IDLE;
                end
            end
            mlr_pkg::S_RD_REQ: begin
                n_state = mlr_pkg::S_RD_WAIT;
            end
            mlr_pkg::S_RD_WAIT: begin
                if (w_out_free) begin
                    n_state = (r_left == mlr_pkg::CNT_W'(1)) ? mlr_pkg::S_IDLE
                                                             : mlr_pkg::S_RD_REQ;
                end
            end
            default: n_state = mlr_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready    = 1'b0;
        w_ram_re   = 1'b0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            mlr_pkg::S_IDLE:    w_ready    = 1'b1;
            mlr_pkg::S_SMP:     w_ram_we   = w_push.done & w_push.wr;
            mlr_pkg::S_RD_REQ:  w_ram_re   = 1'b1;
            mlr_pkg::S_RD_WAIT: w_out_load = w_out_free;
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    assign w_start = w_take & ~w_is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha   <= mlr_pkg::ALPHA_RST;
            r_cfg.adc_max <= mlr_pkg::MAX_RST;
            r_cfg.adc_mid <= mlr_pkg::MID_RST;
            r_cfg.gain    <= mlr_pkg::GAIN_RST;
            r_cfg.step    <= mlr_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (mlr_pkg::t_cfg_idx'(i_cfg_addr))
                mlr_pkg::CFG_ALPHA: r_cfg.alpha   <= i_cfg_data[13:0];
                mlr_pkg::CFG_MAX:   r_cfg.adc_max <= i_cfg_data[11:0];
                mlr_pkg::CFG_MID:   r_cfg.adc_mid <= i_cfg_data[11:0];
                mlr_pkg::CFG_GAIN:  r_cfg.gain    <= i_cfg_data[3:0];
                mlr_pkg::CFG_STEP:  r_cfg.step    <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlr_pkg::S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take && w_is_read) begin
                r_left <= n_left;
            end
            if (w_ram_we) begin
                r_wr_idx <= r_wr_idx + 1'b1;
                // full ring: the oldest entry is overwritten
                if (w_full) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_out_load) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_fill   <= r_fill - 1'b1;
                r_left   <= r_left - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sample <= w_rdata;
            r_out_rem    <= mlr_pkg::REM_W'(r_fill - 1'b1);
            r_out_last   <= (r_left == mlr_pkg::CNT_W'(1));
        end
    end

    mlr_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_raw   ($signed(i_s_axis_tdata[12:0])),
        .i_cfg   (r_cfg),
        .o_push  (w_push)
    );

    mlr_ram #(
        .WIDTH (mlr_pkg::SMP_W),
        .DEPTH (mlr_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (w_push.value),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_rem, r_out_sample};
    assign o_m_axis_tlast  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mlr_pkg::FILL_W'(mlr_pkg::RING_DEPTH))
        else $error("ring fill count above depth");

    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlr_pkg::S_IDLE) |=> $stable(r_fill))
        else $error("fill count moved while idle");

    a_we_smp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == mlr_pkg::S_SMP) && !w_ram_re)
        else $error("ring write outside sample state");

    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlr_pkg::S_RD_REQ || r_state == mlr_pkg::S_RD_WAIT)
        |-> (r_left != '0) && (r_fill != '0))
        else $error("read sequencer running with nothing to deliver");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_left == mlr_pkg::CNT_W'(1)) |=> (r_state == mlr_pkg::S_IDLE))
        else $error("read did not end after last result");

endmodule

[test/mic_lowpass_decimate_ring_unit_tb.sv]
// mic_lowpass_decimate_ring_unit_tb: self-checking bench for the microphone lowpass,
// decimator and sample ring; directed table then random traffic, checked by a
// behavioural predictor. Depends on mlr_pkg and mic_lowpass_decimate_ring_unit.
module mic_lowpass_decimate_ring_unit_tb;

    localparam int     PREDICT        = -1;
    localparam int     SETTLE_CYCLES  = 10;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     IDLE_PCT       = 17;
    localparam longint Q_ONE          = 64'sd1 << mlr_pkg::Q_SHIFT;
    localparam longint PHASE_WRAP     = 64'sd65536;
    localparam int     N_DIRECTED     = 21;

    typedef struct packed {
        logic signed [mlr_pkg::SMP_W-1:0] sample;
        logic [mlr_pkg::REM_W-1:0]        rem;
        logic                             last;
    } t_sample_beat;

    // n_typed: PREDICT, or the number of results typed in (0 or 1, last set)
    typedef struct packed {
        mlr_pkg::t_op op;
        int           raw;
        int           cnt;
        int           n_typed;
        int           smp;
        int           rem;
    } t_stim_row;

    // alpha 8192, mid 0, gain 0, step 32768: filter follows input, every second sample pushed
    localparam t_stim_row DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{mlr_pkg::OP_READ,      0,   5, 0,       0,    0},  // empty ring after reset
        '{mlr_pkg::OP_SAMPLE, 4095,   0, 0,       0,    0},
        '{mlr_pkg::OP_SAMPLE, 4095,   0, 0,       0,    0},
        '{mlr_pkg::OP_READ,      0,   0, 0,       0,    0},  // zero count
        '{mlr_pkg::OP_READ,      0,   1, 1,    4095,    0},
        '{mlr_pkg::OP_SAMPLE, -4096,  0, 0,       0,    0},  // negative reading clamps to zero
        '{mlr_pkg::OP_SAMPLE,   -1,   0, 0,       0,    0},
        '{mlr_pkg::OP_READ,      0,   3, 1,       0,    0},
        '{mlr_pkg::OP_SAMPLE,    0,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE, 4095,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE, 2047,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE,    1,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE, 4094,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE, 4095,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_READ,      0, 127, PREDICT, 0,    0},  // count above the read limit
        '{mlr_pkg::OP_SAMPLE, 4095,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE, 4095,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE,  100,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_SAMPLE,  200,   0, PREDICT, 0,    0},
        '{mlr_pkg::OP_READ,      0,   1, PREDICT, 0,    0},
        '{mlr_pkg::OP_READ,      0,  64, PREDICT, 0,    0}
    };

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [23:0]                  i_s_axis_tdata  = '0;  // raw_sample[12:0], read_count[19:13]
    logic                         i_s_axis_tuser  = 1'b0;  // operation[0]
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [31:0]                  o_m_axis_tdata;  // sample[15:0], remaining[26:16]
    logic                         o_m_axis_tlast;
    logic                         i_cfg_we        = 1'b0;
    logic [mlr_pkg::CFG_AW-1:0]   i_cfg_addr      = '0;
    logic [mlr_pkg::CFG_DW-1:0]   i_cfg_data      = '0;

    // register copies and filter / ring state
    int cfg_alpha = int'(mlr_pkg::ALPHA_RST);
    int cfg_max   = int'(mlr_pkg::MAX_RST);
    int cfg_mid   = int'(mlr_pkg::MID_RST);
    int cfg_gain  = int'(mlr_pkg::GAIN_RST);
    int cfg_step  = int'(mlr_pkg::STEP_RST);

    int                               filt_q   = 0;
    longint                           phase_acc = 0;
    logic signed [mlr_pkg::SMP_W-1:0] ring_mem [mlr_pkg::RING_DEPTH];
    int                               wr_ptr   = 0;
    int                               rd_ptr   = 0;
    int                               fill     = 0;

    t_sample_beat pending_samples [$];
    int           n_bad       = 0;
    int           quiet_cycles = 0;
    logic         calm        = 1'b0;
    int           hold_asked  = 0;
    int           hold_taken  = 0;
    int           hold_left   = 0;

    mic_lowpass_decimate_ring_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [mlr_pkg::SMP_W-1:0] clip16(input longint v);
        logic signed [mlr_pkg::SMP_W-1:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[mlr_pkg::SMP_W-1:0];
        end
        return r;
    endfunction

    // advances the filter, phase and ring; keep queues the read results
    function automatic void filter_ring_apply(input mlr_pkg::t_op op,
                                              input logic signed [mlr_pkg::RAW_W-1:0] raw,
                                              input logic [mlr_pkg::CNT_W-1:0] cnt,
                                              input bit keep);
        longint       x;
        longint       acc;
        int           want;
        int           take;
        t_sample_beat b;
        if (op == mlr_pkg::OP_SAMPLE) begin
            x = longint'(raw);
            if (x < 0) x = 0;
            if (x > cfg_max) x = cfg_max;
            x = x - cfg_mid;
            acc = x * cfg_alpha + longint'(filt_q) * (Q_ONE - cfg_alpha);
            filt_q = int'(clip16(acc >>> mlr_pkg::Q_SHIFT));
            phase_acc = phase_acc + cfg_step;
            if (phase_acc >= PHASE_WRAP) begin
                phase_acc = phase_acc - PHASE_WRAP;
                ring_mem[wr_ptr] = clip16(longint'(filt_q) <<< cfg_gain);
                wr_ptr = (wr_ptr + 1) % mlr_pkg::RING_DEPTH;
                // full ring drops its oldest entry
                if (fill < mlr_pkg::RING_DEPTH) fill++;
                else rd_ptr = (rd_ptr + 1) % mlr_pkg::RING_DEPTH;
            end
        end else begin
            want = (int'(cnt) > mlr_pkg::MAX_READ) ? mlr_pkg::MAX_READ : int'(cnt);
            take = (fill < want) ? fill : want;
            for (int k = 0; k < take; k++) begin
                b.sample = ring_mem[rd_ptr];
                rd_ptr = (rd_ptr + 1) % mlr_pkg::RING_DEPTH;
                fill--;
                b.rem  = mlr_pkg::REM_W'(fill);
                b.last = (k + 1 == take);
                if (keep) pending_samples.push_back(b);
            end
        end
    endfunction

    task automatic offer(input mlr_pkg::t_op op,
                         input logic signed [mlr_pkg::RAW_W-1:0] raw,
                         input logic [mlr_pkg::CNT_W-1:0] cnt, input int n_typed,
                         input logic signed [mlr_pkg::SMP_W-1:0] smp,
                         input logic [mlr_pkg::REM_W-1:0] rem);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0, cnt, raw};
        do @(posedge i_clk); while (!o_s_axis_tready);
        filter_ring_apply(op, raw, cnt, n_typed == PREDICT);
        if (n_typed == 1) pending_samples.push_back('{smp, rem, 1'b1});
    endtask

    task automatic cfg_write(input logic [mlr_pkg::CFG_AW-1:0] addr,
                             input logic [mlr_pkg::CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            mlr_pkg::CFG_ALPHA: cfg_alpha = int'(data[13:0]);
            mlr_pkg::CFG_MAX:   cfg_max   = int'(data[11:0]);
            mlr_pkg::CFG_MID:   cfg_mid   = int'(data[11:0]);
            mlr_pkg::CFG_GAIN:  cfg_gain  = int'(data[3:0]);
            mlr_pkg::CFG_STEP:  cfg_step  = int'(data[15:0]);
            default: ;
        endcase
    endtask

    // registers change only once the block has drained
    task automatic apply_settings(input int alpha, input int maxv, input int mid,
                                  input int gain, input int step);
        i_s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(mlr_pkg::CFG_ALPHA, mlr_pkg::CFG_DW'(alpha));
        cfg_write(mlr_pkg::CFG_MAX, mlr_pkg::CFG_DW'(maxv));
        cfg_write(mlr_pkg::CFG_MID, mlr_pkg::CFG_DW'(mid));
        cfg_write(mlr_pkg::CFG_GAIN, mlr_pkg::CFG_DW'(gain));
        cfg_write(mlr_pkg::CFG_STEP, mlr_pkg::CFG_DW'(step));
        // an unmapped index must leave every register alone
        cfg_write(mlr_pkg::CFG_AW'(int'(mlr_pkg::CFG_STEP) + $urandom_range(1, 3)),
                  mlr_pkg::CFG_DW'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n_items, input int read_pct);
        mlr_pkg::t_op                     op;
        logic signed [mlr_pkg::RAW_W-1:0] raw;
        logic [mlr_pkg::CNT_W-1:0]        cnt;
        for (int i = 0; i < n_items; i++) begin
            op  = ($urandom_range(99) < read_pct) ? mlr_pkg::OP_READ : mlr_pkg::OP_SAMPLE;
            raw = mlr_pkg::RAW_W'($urandom);
            cnt = ($urandom_range(7) == 0) ? mlr_pkg::CNT_W'($urandom)
                                           : mlr_pkg::CNT_W'($urandom_range(1, mlr_pkg::MAX_READ));
            offer(op, raw, cnt, PREDICT, '0, '0);
        end
    endtask

    // receiver: random stalls, calm stretches and one long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken      <= hold_taken + 1;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sample_beat got;
        t_sample_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.sample = o_m_axis_tdata[15:0];
            got.rem    = o_m_axis_tdata[26:16];
            got.last   = o_m_axis_tlast;
            if (pending_samples.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: sample %0d remaining %0d last %0b",
                             $signed(got.sample), got.rem, got.last);
            end else begin
                want = pending_samples.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 $signed(want.sample), want.rem, want.last,
                                 $signed(got.sample), got.rem, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_settings(8192, 4095, 0, 0, 32768);
        for (int r = 0; r < N_DIRECTED; r++) begin
            offer(DIRECTED_ROWS[r].op, mlr_pkg::RAW_W'(DIRECTED_ROWS[r].raw),
                  mlr_pkg::CNT_W'(DIRECTED_ROWS[r].cnt), DIRECTED_ROWS[r].n_typed,
                  mlr_pkg::SMP_W'(DIRECTED_ROWS[r].smp), mlr_pkg::REM_W'(DIRECTED_ROWS[r].rem));
        end

        apply_settings(int'(mlr_pkg::ALPHA_RST), int'(mlr_pkg::MAX_RST), int'(mlr_pkg::MID_RST),
                       int'(mlr_pkg::GAIN_RST), int'(mlr_pkg::STEP_RST));
        run_random(120, 25);
        // alpha zero holds the filter, full gain saturates
        apply_settings(0, 0, 0, 15, 65535);
        run_random(40, 30);
        // weight of the old value goes negative
        apply_settings(16383, 4095, 4095, 15, 1);
        run_random(40, 30);
        for (int p = 0; p < 3; p++) begin
            apply_settings($urandom_range(16383), $urandom_range(4095), $urandom_range(4095),
                           $urandom_range(15), $urandom_range(65535));
            calm <= (p == 1);
            run_random(60, 30);
        end
        calm <= 1'b0;

        // long run of pushes, then full-size reads against a held-off receiver
        apply_settings(7000, 4095, 2048, 2, 65535);
        run_random(100, 0);
        hold_asked <= hold_asked + 1;
        for (int k = 0; k < 3; k++) begin
            offer(mlr_pkg::OP_READ, mlr_pkg::RAW_W'($urandom),
                  mlr_pkg::CNT_W'(mlr_pkg::MAX_READ), PREDICT, '0, '0);
        end
        offer(mlr_pkg::OP_READ, '0, 7'd127, PREDICT, '0, '0);

        apply_settings(4096, 3000, 1000, 1, 0);
        run_random(30, 30);

        i_s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && pending_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
